>>> rtl/lttb_downsampler_macros.svh
// Assertion macros shared by the downsampler RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef LTTB_DOWNSAMPLER_MACROS_SVH
`define LTTB_DOWNSAMPLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LTTB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LTTB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lttb_pkg.sv
// Shared types and constants for the downsampler.
// No dependencies.
package lttb_pkg;

  localparam int DEF_MAX_BUCKET_POINTS = 256;
  localparam int DEF_COORD_BITS        = 16;

  localparam int VW_W   = 13;
  localparam int MBW_W  = 8;
  localparam int LEN_W  = 17;
  localparam int NB_W   = 13;
  localparam int CFG_W  = 17;
  localparam int CIDX_W = 2;

  localparam logic [CIDX_W-1:0] REG_VIEW_WIDTH = 2'd0;
  localparam logic [CIDX_W-1:0] REG_MIN_BUCKET = 2'd1;
  localparam logic [CIDX_W-1:0] REG_SERIES_LEN = 2'd2;

  localparam logic [VW_W-1:0]  RST_VIEW_WIDTH = 13'd640;
  localparam logic [MBW_W-1:0] RST_MIN_BUCKET = 8'd3;
  localparam logic [LEN_W-1:0] RST_SERIES_LEN = 17'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NB_GO,
    S_NB_WAIT,
    S_BR_MUL,
    S_BR_GO,
    S_BR_WAIT,
    S_DISPATCH,
    S_AVGX_GO,
    S_AVGX_WAIT,
    S_AVGY_GO,
    S_AVGY_WAIT,
    S_RANK,
    S_RANK_OUT,
    S_MID_UPD,
    S_EMIT
  } state_t;

endpackage

>>> rtl/lttb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lttb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/lttb_div.sv
// Restoring divider, one quotient bit per cycle, shared by the control FSM.
// No dependencies.
module lttb_div #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             qbit;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign qbit  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], qbit};
      rem_r <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = num_r;
  assign rem  = rem_r;

endmodule

>>> rtl/lttb_cell.sv
// One multiply-accumulate cell of the area chain; passes its point onward.
// No dependencies.
module lttb_cell #(
  parameter int OPW   = 17,
  parameter int ACC_W = 36,
  parameter int PT_W  = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    vld_in,
  input  logic [PT_W-1:0]         pt_in,
  input  logic signed [ACC_W-1:0] acc_in,
  input  logic signed [OPW-1:0]   op_a,
  input  logic signed [OPW-1:0]   op_b,
  output logic                    vld_out,
  output logic [PT_W-1:0]         pt_out,
  output logic signed [ACC_W-1:0] acc_out
);

  logic signed [2*OPW-1:0] prod;
  logic                    vld_r;
  logic [PT_W-1:0]         pt_r;
  logic signed [ACC_W-1:0] acc_r;

  assign prod = op_a * op_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    pt_r  <= pt_in;
    acc_r <= acc_in + ACC_W'(prod);
  end

  assign vld_out = vld_r;
  assign pt_out  = pt_r;
  assign acc_out = acc_r;

endmodule

>>> rtl/lttb_downsampler.sv
// Largest-triangle-three-buckets downsampler over a series of known length.
// Uses lttb_pkg, lttb_ram, lttb_div, lttb_cell and lttb_downsampler_macros.svh.
//
// Points arrive on the in_ channel, one per transfer; selected points leave on
// the out_ channel, the final one of a series with out_is_last set. Each input
// transfer yields zero to three output transfers.
// The configuration port takes a write in any cycle. After reset and after each
// write the block recomputes its bucket count with the shared divider, and its
// bucket position too when a series is in progress, holding in_stall high
// meanwhile. A point is handled one at a time. A plain point passes through
// dispatch and the bucket update before the next transfer is accepted, and a
// point that is passed on goes through dispatch and the emit state to the out_
// channel. A point that closes a bucket also takes two serial divisions for the
// next-bucket average and then streams the stored bucket through the RAM read
// port and a three-cell multiply chain, one point per cycle, then drains the
// chain and places the result. The divider and the single RAM read port bound
// the pace of this path. Results go through one output register; while
// out_stall is high the result holds and the block waits before placing the
// next one. Reset clears all control state and loads the register defaults.
module lttb_downsampler #(
  parameter int MAX_BUCKET_POINTS = lttb_pkg::DEF_MAX_BUCKET_POINTS,
  parameter int COORD_BITS        = lttb_pkg::DEF_COORD_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [lttb_pkg::CIDX_W-1:0] cfg_index,
  input  logic [lttb_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [COORD_BITS-1:0]       in_point_x,
  input  logic [COORD_BITS-1:0]       in_point_y,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [COORD_BITS-1:0]       out_x,
  output logic [COORD_BITS-1:0]       out_y,
  output logic                        out_is_last
);

  import lttb_pkg::*;

  `include "lttb_downsampler_macros.svh"

  localparam int C       = COORD_BITS;
  localparam int PT_W    = 2 * C;
  localparam int FILL_W  = $clog2(MAX_BUCKET_POINTS + 1);
  localparam int AW      = $clog2(2 * MAX_BUCKET_POINTS);
  localparam int SUM_W   = C + LEN_W;
  localparam int PROD_W  = LEN_W + NB_W;
  localparam int DIV_NW  = (SUM_W > PROD_W) ? SUM_W : PROD_W;
  localparam int OPW     = C + 1;
  localparam int ACC_W   = 2 * C + 4;
  localparam int NCELL   = 3;

  state_t state_r, state_nxt;

  logic [VW_W-1:0]   vw_r, vw_nxt;
  logic [MBW_W-1:0]  mbw_r, mbw_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [NB_W-1:0]   nb_r, nb_nxt;
  logic              dirty_r, dirty_nxt;
  logic [C-1:0]      px_r, px_nxt, py_r, py_nxt;
  logic [LEN_W-1:0]  pc_r, pc_nxt;
  logic [NB_W-1:0]   bc_r, bc_nxt;
  logic [FILL_W-1:0] fill_r [2];
  logic [FILL_W-1:0] fill_nxt [2];
  logic [SUM_W-1:0]  sx_r, sx_nxt, sy_r, sy_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [PT_W-1:0]   prev_r, prev_nxt;
  logic [NB_W-1:0]   q_r, q_nxt;
  logic [LEN_W-1:0]  r_r, r_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [C-1:0]      ax_r, ax_nxt, ay_r, ay_nxt;
  logic              rb_r, rb_nxt;
  logic [FILL_W-1:0] k_r, k_nxt;
  logic              have_r, have_nxt;
  logic [ACC_W-1:0]  best_r, best_nxt;
  logic [PT_W-1:0]   pick_r, pick_nxt;
  logic              jobb_r, jobb_nxt;
  logic              mid_r, mid_nxt;
  logic              elast_r, elast_nxt;
  logic              ov_r, ov_nxt;
  logic [C-1:0]      ox_r, ox_nxt, oy_r, oy_nxt;
  logic              olast_r, olast_nxt;
  logic              rd_vld_r;

  logic [LEN_W-1:0]  len_eff, w_eff, pcm1, dden;
  logic [NB_W-1:0]   nbm2, bnew, q13;
  logic [LEN_W:0]    pc_inc, rsum;
  logic              in_acc, slot_free, passthru, is_last_pt, chg, bank, issue, draining;
  logic [FILL_W-1:0] fe;

  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [LEN_W-1:0]  div_den, div_rem;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [PT_W-1:0]   ram_rdata;

  logic                    vld_c [NCELL+1];
  logic [PT_W-1:0]         pt_c  [NCELL+1];
  logic signed [ACC_W-1:0] acc_c [NCELL+1];
  logic signed [OPW-1:0]   opa_c [NCELL];
  logic signed [OPW-1:0]   opb_c [NCELL];
  logic [ACC_W-1:0]        mag;

  assign len_eff    = (len_r == '0) ? LEN_W'(1) : len_r;
  assign w_eff      = (mbw_r == '0) ? LEN_W'(1) : LEN_W'(mbw_r);
  assign pcm1       = pc_r - LEN_W'(1);
  assign dden       = len_eff - LEN_W'(2);
  assign nbm2       = nb_r - NB_W'(2);
  assign bnew       = q_r + NB_W'(1);
  assign q13        = div_quo[NB_W-1:0];
  assign pc_inc     = (LEN_W+1)'(pc_r) + (LEN_W+1)'(1);
  assign rsum       = (LEN_W+1)'(r_r) + (LEN_W+1)'(nbm2);
  assign passthru   = LEN_W'(nb_r) > len_eff;
  assign is_last_pt = pc_inc >= (LEN_W+1)'(len_eff);
  assign chg        = bnew != bc_r;
  assign bank       = bnew[0];
  assign fe         = chg ? '0 : fill_r[bank];

  assign in_stall  = (state_r != S_IDLE) || dirty_r;
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !ov_r || !out_stall;

  assign issue     = (state_r == S_RANK) && (k_r < fill_r[rb_r]);
  assign ram_raddr = (rb_r ? AW'(MAX_BUCKET_POINTS) : AW'(0)) + AW'(k_r);
  assign draining  = rd_vld_r || vld_c[1] || vld_c[2] || vld_c[3];

  lttb_div #(
    .NUM_W(DIV_NW),
    .DEN_W(LEN_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo),
    .rem  (div_rem)
  );

  lttb_ram #(
    .WIDTH(PT_W),
    .DEPTH(2 * MAX_BUCKET_POINTS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({py_r, px_r}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign vld_c[0] = rd_vld_r;
  assign pt_c[0]  = ram_rdata;
  assign acc_c[0] = '0;

  for (genvar g = 0; g < NCELL; g++) begin : g_chain
    if (g == 0) begin : g_op
      assign opa_c[g] = signed'({1'b0, prev_r[C-1:0]});
      assign opb_c[g] = signed'({1'b0, pt_c[g][PT_W-1:C]} - {1'b0, ay_r});
    end else if (g == 1) begin : g_op
      assign opa_c[g] = signed'({1'b0, pt_c[g][C-1:0]});
      assign opb_c[g] = signed'({1'b0, ay_r} - {1'b0, prev_r[PT_W-1:C]});
    end else begin : g_op
      assign opa_c[g] = signed'({1'b0, ax_r});
      assign opb_c[g] = signed'({1'b0, prev_r[PT_W-1:C]} - {1'b0, pt_c[g][PT_W-1:C]});
    end

    lttb_cell #(
      .OPW  (OPW),
      .ACC_W(ACC_W),
      .PT_W (PT_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_in (vld_c[g]),
      .pt_in  (pt_c[g]),
      .acc_in (acc_c[g]),
      .op_a   (opa_c[g]),
      .op_b   (opb_c[g]),
      .vld_out(vld_c[g+1]),
      .pt_out (pt_c[g+1]),
      .acc_out(acc_c[g+1])
    );
  end

  assign mag = (acc_c[NCELL] < 0) ? ACC_W'(-acc_c[NCELL]) : ACC_W'(acc_c[NCELL]);

  always_comb begin
    state_nxt   = state_r;
    vw_nxt      = vw_r;
    mbw_nxt     = mbw_r;
    len_nxt     = len_r;
    nb_nxt      = nb_r;
    dirty_nxt   = dirty_r;
    px_nxt      = px_r;
    py_nxt      = py_r;
    pc_nxt      = pc_r;
    bc_nxt      = bc_r;
    fill_nxt[0] = fill_r[0];
    fill_nxt[1] = fill_r[1];
    sx_nxt      = sx_r;
    sy_nxt      = sy_r;
    cnt_nxt     = cnt_r;
    prev_nxt    = prev_r;
    q_nxt       = q_r;
    r_nxt       = r_r;
    prod_nxt    = prod_r;
    ax_nxt      = ax_r;
    ay_nxt      = ay_r;
    rb_nxt      = rb_r;
    k_nxt       = k_r;
    have_nxt    = have_r;
    best_nxt    = best_r;
    pick_nxt    = pick_r;
    jobb_nxt    = jobb_r;
    mid_nxt     = mid_r;
    elast_nxt   = elast_r;
    ov_nxt      = ov_r && out_stall;
    ox_nxt      = ox_r;
    oy_nxt      = oy_r;
    olast_nxt   = olast_r;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;
    ram_we      = 1'b0;
    ram_waddr   = '0;

    if (issue) begin
      k_nxt = k_r + FILL_W'(1);
    end
    if (vld_c[NCELL] && (!have_r || (mag > best_r))) begin
      have_nxt = 1'b1;
      best_nxt = mag;
      pick_nxt = pt_c[NCELL];
    end

    case (state_r)
      S_IDLE: begin
        if (dirty_r) begin
          state_nxt = S_NB_GO;
        end else if (in_acc) begin
          px_nxt    = in_point_x;
          py_nxt    = in_point_y;
          state_nxt = S_DISPATCH;
        end
      end
      S_NB_GO: begin
        div_start = 1'b1;
        div_num   = DIV_NW'(vw_r) + DIV_NW'(w_eff) - DIV_NW'(1);
        div_den   = w_eff;
        state_nxt = S_NB_WAIT;
      end
      S_NB_WAIT: begin
        if (div_done) begin
          nb_nxt    = (q13 < NB_W'(2)) ? NB_W'(2) : q13;
          state_nxt = S_BR_MUL;
        end
      end
      S_BR_MUL: begin
        if ((pc_r != '0) && (len_eff >= LEN_W'(3)) && !passthru) begin
          prod_nxt  = PROD_W'(pcm1) * PROD_W'(nbm2);
          state_nxt = S_BR_GO;
        end else begin
          dirty_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      S_BR_GO: begin
        div_start = 1'b1;
        div_num   = DIV_NW'(prod_r);
        div_den   = dden;
        state_nxt = S_BR_WAIT;
      end
      S_BR_WAIT: begin
        if (div_done) begin
          q_nxt     = q13;
          r_nxt     = div_rem;
          dirty_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      S_DISPATCH: begin
        jobb_nxt = 1'b0;
        mid_nxt  = 1'b0;
        if (passthru) begin
          elast_nxt = is_last_pt;
          if (!is_last_pt) begin
            pc_nxt = pc_inc[LEN_W-1:0];
          end
          state_nxt = S_EMIT;
        end else if (pc_r == '0) begin
          pc_nxt      = LEN_W'(1);
          bc_nxt      = '0;
          fill_nxt[0] = '0;
          fill_nxt[1] = '0;
          sx_nxt      = '0;
          sy_nxt      = '0;
          cnt_nxt     = '0;
          prev_nxt    = {py_r, px_r};
          q_nxt       = '0;
          r_nxt       = '0;
          elast_nxt   = 1'b0;
          state_nxt   = S_EMIT;
        end else if (is_last_pt) begin
          if (bc_r >= NB_W'(2)) begin
            rb_nxt    = ~bc_r[0];
            jobb_nxt  = (bc_r + NB_W'(1)) < nb_r;
            state_nxt = S_AVGX_GO;
          end else if ((bc_r >= NB_W'(1)) && ((bc_r + NB_W'(1)) < nb_r)) begin
            ax_nxt    = px_r;
            ay_nxt    = py_r;
            rb_nxt    = bc_r[0];
            k_nxt     = '0;
            have_nxt  = 1'b0;
            state_nxt = S_RANK;
          end else begin
            elast_nxt = 1'b1;
            state_nxt = S_EMIT;
          end
        end else begin
          mid_nxt = 1'b1;
          if (chg && (bc_r >= NB_W'(2))) begin
            rb_nxt    = ~bc_r[0];
            state_nxt = S_AVGX_GO;
          end else begin
            state_nxt = S_MID_UPD;
          end
        end
      end
      S_AVGX_GO: begin
        div_start = 1'b1;
        div_num   = DIV_NW'(sx_r);
        div_den   = cnt_r;
        state_nxt = S_AVGX_WAIT;
      end
      S_AVGX_WAIT: begin
        if (div_done) begin
          ax_nxt    = (cnt_r == '0) ? '0 : div_quo[C-1:0];
          state_nxt = S_AVGY_GO;
        end
      end
      S_AVGY_GO: begin
        div_start = 1'b1;
        div_num   = DIV_NW'(sy_r);
        div_den   = cnt_r;
        state_nxt = S_AVGY_WAIT;
      end
      S_AVGY_WAIT: begin
        if (div_done) begin
          ay_nxt    = (cnt_r == '0) ? '0 : div_quo[C-1:0];
          k_nxt     = '0;
          have_nxt  = 1'b0;
          state_nxt = S_RANK;
        end
      end
      S_RANK: begin
        if (!issue && !draining) begin
          state_nxt = S_RANK_OUT;
        end
      end
      S_RANK_OUT: begin
        if (!have_r || slot_free) begin
          if (have_r) begin
            ov_nxt    = 1'b1;
            ox_nxt    = pick_r[C-1:0];
            oy_nxt    = pick_r[PT_W-1:C];
            olast_nxt = 1'b0;
            prev_nxt  = pick_r;
          end
          if (jobb_r) begin
            jobb_nxt  = 1'b0;
            ax_nxt    = px_r;
            ay_nxt    = py_r;
            rb_nxt    = bc_r[0];
            k_nxt     = '0;
            have_nxt  = 1'b0;
            state_nxt = S_RANK;
          end else if (mid_r) begin
            state_nxt = S_MID_UPD;
          end else begin
            elast_nxt = 1'b1;
            state_nxt = S_EMIT;
          end
        end
      end
      S_MID_UPD: begin
        if (fe < FILL_W'(MAX_BUCKET_POINTS)) begin
          ram_we         = 1'b1;
          ram_waddr      = (bank ? AW'(MAX_BUCKET_POINTS) : AW'(0)) + AW'(fe);
          fill_nxt[bank] = fe + FILL_W'(1);
        end else begin
          fill_nxt[bank] = fe;
        end
        if (chg) begin
          bc_nxt  = bnew;
          sx_nxt  = SUM_W'(px_r);
          sy_nxt  = SUM_W'(py_r);
          cnt_nxt = LEN_W'(1);
        end else begin
          sx_nxt  = sx_r + SUM_W'(px_r);
          sy_nxt  = sy_r + SUM_W'(py_r);
          cnt_nxt = cnt_r + LEN_W'(1);
        end
        pc_nxt = pc_inc[LEN_W-1:0];
        if (rsum >= (LEN_W+1)'(dden)) begin
          r_nxt = LEN_W'(rsum - (LEN_W+1)'(dden));
          q_nxt = q_r + NB_W'(1);
        end else begin
          r_nxt = rsum[LEN_W-1:0];
        end
        state_nxt = S_IDLE;
      end
      S_EMIT: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ox_nxt    = px_r;
          oy_nxt    = py_r;
          olast_nxt = elast_r;
          if (elast_r) begin
            pc_nxt      = '0;
            bc_nxt      = '0;
            fill_nxt[0] = '0;
            fill_nxt[1] = '0;
            sx_nxt      = '0;
            sy_nxt      = '0;
            cnt_nxt     = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_wr_en) begin
      dirty_nxt = 1'b1;
      case (cfg_index)
        REG_VIEW_WIDTH: vw_nxt  = cfg_data[VW_W-1:0];
        REG_MIN_BUCKET: mbw_nxt = cfg_data[MBW_W-1:0];
        REG_SERIES_LEN: len_nxt = cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
      if ((state_r == S_NB_GO) || (state_r == S_NB_WAIT) || (state_r == S_BR_MUL) ||
          (state_r == S_BR_GO) || (state_r == S_BR_WAIT)) begin
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      vw_r      <= RST_VIEW_WIDTH;
      mbw_r     <= RST_MIN_BUCKET;
      len_r     <= RST_SERIES_LEN;
      nb_r      <= NB_W'(2);
      dirty_r   <= 1'b1;
      pc_r      <= '0;
      bc_r      <= '0;
      fill_r[0] <= '0;
      fill_r[1] <= '0;
      sx_r      <= '0;
      sy_r      <= '0;
      cnt_r     <= '0;
      prev_r    <= '0;
      q_r       <= '0;
      r_r       <= '0;
      k_r       <= '0;
      have_r    <= 1'b0;
      jobb_r    <= 1'b0;
      mid_r     <= 1'b0;
      elast_r   <= 1'b0;
      ov_r      <= 1'b0;
      rd_vld_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      vw_r      <= vw_nxt;
      mbw_r     <= mbw_nxt;
      len_r     <= len_nxt;
      nb_r      <= nb_nxt;
      dirty_r   <= dirty_nxt;
      pc_r      <= pc_nxt;
      bc_r      <= bc_nxt;
      fill_r[0] <= fill_nxt[0];
      fill_r[1] <= fill_nxt[1];
      sx_r      <= sx_nxt;
      sy_r      <= sy_nxt;
      cnt_r     <= cnt_nxt;
      prev_r    <= prev_nxt;
      q_r       <= q_nxt;
      r_r       <= r_nxt;
      k_r       <= k_nxt;
      have_r    <= have_nxt;
      jobb_r    <= jobb_nxt;
      mid_r     <= mid_nxt;
      elast_r   <= elast_nxt;
      ov_r      <= ov_nxt;
      rd_vld_r  <= issue;
    end
  end

  always_ff @(posedge clk) begin
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    prod_r  <= prod_nxt;
    ax_r    <= ax_nxt;
    ay_r    <= ay_nxt;
    rb_r    <= rb_nxt;
    best_r  <= best_nxt;
    pick_r  <= pick_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid   = ov_r;
  assign out_x       = ox_r;
  assign out_y       = oy_r;
  assign out_is_last = olast_r;

  `LTTB_ASSERT_NEXT(a_accept_dispatch, in_acc, state_r == S_DISPATCH, "accepted point not dispatched")
  `LTTB_ASSERT_NOW(a_fill_bound, 1'b1, (fill_r[0] <= FILL_W'(MAX_BUCKET_POINTS)) && (fill_r[1] <= FILL_W'(MAX_BUCKET_POINTS)), "bucket fill count overflow")
  `LTTB_ASSERT_NEXT(a_last_clears, (state_r == S_EMIT) && slot_free && elast_r, (pc_r == '0) && out_is_last, "series end did not clear counters")

endmodule

>>> tb/sv/lttb_downsampler_tb.sv
// Self-checking testbench for lttb_downsampler: directed and random series.
// Depends on lttb_pkg and the lttb_downsampler RTL; predicts selections in-line.
// A queue-fed driver and a checking monitor run as clocked always blocks.
module lttb_downsampler_tb;
  import lttb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
  } sel_pt_t;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
  } in_pt_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [CIDX_W-1:0]   cfg_index = REG_VIEW_WIDTH;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [15:0]         in_point_x = '0;
  logic [15:0]         in_point_y = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [15:0]         out_x;
  logic [15:0]         out_y;
  logic                out_is_last;

  lttb_downsampler i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_point_x(in_point_x), .in_point_y(in_point_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_is_last(out_is_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  in_pt_t  pending_pts[$];
  sel_pt_t expected_sel[$];
  int      errors = 0;
  bit      hold_req = 1'b0;

  int          view_w = RST_VIEW_WIDTH;
  int          min_bw = RST_MIN_BUCKET;
  int          ser_len = RST_SERIES_LEN;
  longint      pt_cnt = 0;
  longint      bkt_cnt = 0;
  logic [31:0] bkt_mem [0:511];
  longint      fill_cnt [0:1] = '{0, 0};
  longint      sum_x = 0;
  longint      sum_y = 0;
  longint      avg_cnt = 0;
  logic [31:0] prev_sel = '0;

  function automatic void push_sel(logic [15:0] x, logic [15:0] y, logic last);
    sel_pt_t s;
    s.x = x;
    s.y = y;
    s.last = last;
    expected_sel = {expected_sel, s};
  endfunction

  function automatic longint bucket_count();
    longint w;
    longint nb;
    w = (min_bw == 0) ? 1 : min_bw;
    nb = (view_w + w - 1) / w;
    return (nb < 2) ? 2 : nb;
  endfunction

  function automatic void clear_series();
    pt_cnt = 0;
    bkt_cnt = 0;
    fill_cnt[0] = 0;
    fill_cnt[1] = 0;
    sum_x = 0;
    sum_y = 0;
    avg_cnt = 0;
  endfunction

  function automatic void pick_best(longint bank, longint ax, longint ay);
    longint cnt;
    longint base;
    longint x1, y1, x2, y2, area, best;
    longint pick;
    cnt = fill_cnt[bank & 1];
    base = (bank & 1) * 256;
    x1 = prev_sel[15:0];
    y1 = prev_sel[31:16];
    best = 0;
    pick = 0;
    if (cnt == 0) return;
    if (cnt > 256) cnt = 256;
    for (longint k = 0; k < cnt; k++) begin
      x2 = bkt_mem[base + k][15:0];
      y2 = bkt_mem[base + k][31:16];
      area = x1 * (y2 - ay) + x2 * (ay - y1) + ax * (y1 - y2);
      if (area < 0) area = -area;
      if (area > best) begin
        best = area;
        pick = k;
      end
    end
    prev_sel = bkt_mem[base + pick];
    push_sel(prev_sel[15:0], prev_sel[31:16], 1'b0);
  endfunction

  function automatic void pick_with_average(longint bank);
    longint ax, ay;
    ax = avg_cnt ? sum_x / avg_cnt : 0;
    ay = avg_cnt ? sum_y / avg_cnt : 0;
    pick_best(bank, ax, ay);
  endfunction

  function automatic void predict_selection(logic [15:0] x, logic [15:0] y);
    longint len, nb, i, b, cur, bank;
    len = (ser_len == 0) ? 1 : ser_len;
    nb = bucket_count();
    i = pt_cnt;
    if (nb > len) begin
      push_sel(x, y, (i + 1 >= len));
      if (i + 1 >= len) clear_series();
      else pt_cnt = i + 1;
      return;
    end
    if (i == 0) begin
      clear_series();
      prev_sel = {y, x};
      pt_cnt = 1;
      push_sel(x, y, 1'b0);
      return;
    end
    if (i + 1 >= len) begin
      cur = bkt_cnt;
      if (cur >= 2) pick_with_average(cur - 1);
      if (cur >= 1 && cur + 1 < nb) pick_best(cur, x, y);
      push_sel(x, y, 1'b1);
      clear_series();
      return;
    end
    b = (i - 1) * (nb - 2) / (len - 2) + 1;
    if (b != bkt_cnt) begin
      if (bkt_cnt >= 2) pick_with_average(bkt_cnt - 1);
      bkt_cnt = b & 13'h1FFF;
      fill_cnt[bkt_cnt & 1] = 0;
      sum_x = 0;
      sum_y = 0;
      avg_cnt = 0;
    end
    bank = bkt_cnt & 1;
    if (fill_cnt[bank] < 256) begin
      bkt_mem[bank * 256 + fill_cnt[bank]] = {y, x};
      fill_cnt[bank]++;
    end
    sum_x += x;
    sum_y += y;
    avg_cnt++;
    pt_cnt = i + 1;
  endfunction

  int gap = 0;
  bit burst = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_selection(in_point_x, in_point_y);
      if (in_valid && in_stall) begin
      end else if (gap > 0) begin
        gap--;
        in_valid <= 1'b0;
      end else if (pending_pts.size() > 0) begin
        in_pt_t p;
        p = pending_pts.pop_front();
        in_point_x <= p.x;
        in_point_y <= p.y;
        in_valid <= 1'b1;
        if ($urandom_range(0, 40) == 0) burst = !burst;
        if (!burst) begin
          case ($urandom_range(0, 9))
            0, 1, 2: gap = $urandom_range(1, 3);
            3: gap = $urandom_range(5, 40);
            default: gap = 0;
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  int  hold_cnt = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_sel.size() == 0) begin
          $display("%0t: unexpected transfer x=%h y=%h last=%b",
                   $realtime, out_x, out_y, out_is_last);
          errors++;
        end else begin
          sel_pt_t e;
          e = expected_sel.pop_front();
          if (out_x !== e.x) begin
            $display("%0t: out_x expected %h actual %h", $realtime, e.x, out_x);
            errors++;
          end
          if (out_y !== e.y) begin
            $display("%0t: out_y expected %h actual %h", $realtime, e.y, out_y);
            errors++;
          end
          if (out_is_last !== e.last) begin
            $display("%0t: out_is_last expected %b actual %b", $realtime, e.last,
                     out_is_last);
            errors++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_cnt = 500;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3: out_stall <= 1'b1;
          4: begin
            out_stall <= 1'b1;
            hold_cnt = $urandom_range(5, 40);
          end
          default: out_stall <= 1'b0;
        endcase
      end
    end
  end

  task automatic write_reg(logic [CIDX_W-1:0] idx, int val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    case (idx)
      REG_VIEW_WIDTH: view_w = val & 13'h1FFF;
      REG_MIN_BUCKET: min_bw = val & 8'hFF;
      REG_SERIES_LEN: ser_len = val & 17'h1FFFF;
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_config(int vw, int mbw, int len);
    write_reg(REG_VIEW_WIDTH, vw);
    write_reg(REG_MIN_BUCKET, mbw);
    write_reg(REG_SERIES_LEN, len);
  endtask

  task automatic add_point(int x, int y);
    in_pt_t p;
    p.x = 16'(x);
    p.y = 16'(y);
    pending_pts = {pending_pts, p};
  endtask

  task automatic settle();
    do @(negedge clk); while (pending_pts.size() > 0 || in_valid);
    do @(negedge clk); while (expected_sel.size() > 0);
    repeat (400) @(posedge clk);
  endtask

  initial begin
    int rand_items;
    int len;
    int n;
    bit clustered;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    add_point(0, 0);
    add_point(65535, 65535);
    settle();

    hold_req = 1'b1;
    set_config(10, 1, 12);
    add_point(0, 65535);
    add_point(65535, 0);
    add_point(0, 0);
    add_point(65535, 65535);
    add_point(32768, 1);
    add_point(1, 32768);
    for (int k = 0; k < 5; k++) add_point($urandom_range(0, 65535), $urandom_range(0, 65535));
    add_point(65535, 65535);
    settle();

    set_config(3, 1, 6);
    for (int k = 0; k < 6; k++) add_point(5, 5);
    settle();

    set_config(2, 255, 5);
    for (int k = 0; k < 5; k++) add_point($urandom_range(0, 65535), $urandom_range(0, 65535));
    settle();

    set_config(8191, 1, 65536);
    for (int k = 0; k < 3; k++) add_point($urandom_range(0, 65535), $urandom_range(0, 65535));
    settle();

    set_config(8191, 1, 1);
    add_point(65535, 0);
    add_point(0, 65535);
    settle();

    set_config(3, 1, 259);
    for (int k = 0; k < 259; k++) add_point($urandom_range(0, 65535), $urandom_range(0, 65535));
    settle();

    rand_items = 0;
    while (rand_items < 8) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
      case ($urandom_range(0, 7))
        0: set_config(8191, $urandom_range(1, 255), len);
        1: set_config($urandom_range(1, 80), 255, len);
        default: set_config($urandom_range(1, 80), $urandom_range(1, 10), len);
      endcase
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : len;
      clustered = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < n; k++) begin
        if (clustered) add_point($urandom_range(100, 103), $urandom_range(7, 9));
        else add_point($urandom_range(0, 65535), $urandom_range(0, 65535));
      end
      rand_items += n;
      settle();
    end

    if (errors == 0) $display("lttb_downsampler_tb: PASS");
    else $display("lttb_downsampler_tb: FAIL");
    $finish;
  end

  initial begin
    #4ms;
    $display("lttb_downsampler_tb: FAIL");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/lttb_pkg.sv
rtl/lttb_ram.sv
rtl/lttb_div.sv
rtl/lttb_cell.sv
rtl/lttb_downsampler.sv
tb/sv/lttb_downsampler_tb.sv
